### rtl/core/gcd_pkg.sv
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared types, constants and helper functions for the great-circle
// distance pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gcd_pkg;

  // default configuration
  localparam int ANGLE_BITS_DEF     = 32;
  localparam int DIST_FRAC_BITS_DEF = 16;

  // fixed-point formats
  localparam int TRIG_FRAC    = 30;
  localparam int CORDIC_ITERS = 31;
  localparam int XY_W         = 34;
  localparam int Z_W          = 64;
  localparam int ROT_LANES    = 4;
  localparam int SQ_LANES     = 2;
  localparam int SQ_N_W       = 2 * TRIG_FRAC + 1;
  localparam int SQ_RES_W     = SQ_N_W + 1;
  localparam int SQ_OUT_W     = TRIG_FRAC + 1;
  localparam int NUM_W        = 58;
  localparam int QINT_BITS    = 15;
  localparam int MAX_NM       = 10800;
  localparam int MIN_PER_TURN = 21600;

  typedef logic signed [XY_W-1:0] xy_t;
  typedef logic signed [Z_W-1:0]  ang_t;

  localparam logic [63:0] PI_Q60    = 64'h3243F6A8885A308D;
  localparam logic [31:0] PI_LO     = PI_Q60[31:0];
  localparam logic [29:0] PI_HI     = PI_Q60[61:32];
  localparam logic [63:0] PI_Q40    = PI_Q60 >> 20;
  localparam xy_t         CORDIC_X0 = 34'sd652032874;
  localparam xy_t         TRIG_ONE  = xy_t'(1) <<< TRIG_FRAC;

  // floor(2^e / d) by shift-subtract, used at elaboration only
  function automatic logic [63:0] pow2_div(input int e, input int d);
    logic [63:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], (b == e)};
      if (r >= 64'(d)) begin
        r    = r - 64'(d);
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q60, truncated alternating series
  function automatic ang_t atan_q60(input int i);
    ang_t sum;
    ang_t t;
    int   e;
    sum = '0;
    if (i == 0) begin
      sum = ang_t'(PI_Q60 >> 2);
    end else begin
      for (int k = 0; k < 64; k++) begin
        e = 60 - i * (2 * k + 1);
        if (e >= 0) begin
          t   = ang_t'(pow2_div(e, 2 * k + 1));
          sum = k[0] ? sum - t : sum + t;
        end
      end
    end
    return sum;
  endfunction

  // q30 by q30 product, magnitude truncated toward zero
  function automatic xy_t mulq(input xy_t a, input xy_t b);
    logic [XY_W-1:0]   ua;
    logic [XY_W-1:0]   ub;
    logic [2*XY_W-1:0] p;
    xy_t               m;
    ua = a[XY_W-1] ? XY_W'(-a) : XY_W'(a);
    ub = b[XY_W-1] ? XY_W'(-b) : XY_W'(b);
    p  = {{XY_W{1'b0}}, ua} * {{XY_W{1'b0}}, ub};
    m  = xy_t'(p >> TRIG_FRAC);
    return (a[XY_W-1] != b[XY_W-1]) ? -m : m;
  endfunction

endpackage

### rtl/core/gcd_rot.sv
// ----------------------------------------------------------------------------
// gcd_rot
// Four-lane rotation-mode cordic, one micro-rotation per register stage,
// giving cosine and sine of each lane angle in q30.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcd_rot (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  gcd_pkg::ang_t       in_z [gcd_pkg::ROT_LANES],
  input  logic [1:0]          in_neg,
  output logic                out_valid,
  output gcd_pkg::xy_t        out_x [gcd_pkg::ROT_LANES],
  output gcd_pkg::xy_t        out_y [gcd_pkg::ROT_LANES],
  output logic [1:0]          out_neg
);
  import gcd_pkg::*;

  xy_t        x_r   [CORDIC_ITERS][ROT_LANES];
  xy_t        y_r   [CORDIC_ITERS][ROT_LANES];
  ang_t       z_r   [CORDIC_ITERS][ROT_LANES];
  logic [1:0] neg_r [CORDIC_ITERS];
  logic       v_r   [CORDIC_ITERS];

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_stage
    localparam ang_t ATAN_I = atan_q60(i);
    logic       v_in;
    logic [1:0] neg_in;

    if (i == 0) begin : g_src_in
      assign v_in   = in_valid;
      assign neg_in = in_neg;
    end else begin : g_src_prev
      assign v_in   = v_r[i-1];
      assign neg_in = neg_r[i-1];
    end

    // valid bit travels with the beat
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[i] <= neg_in;
      end
    end

    for (genvar l = 0; l < ROT_LANES; l++) begin : g_lane
      xy_t  xp, yp, x_nxt, y_nxt;
      ang_t zp, z_nxt;

      if (i == 0) begin : g_init
        assign xp = CORDIC_X0;
        assign yp = '0;
        assign zp = in_z[l];
      end else begin : g_chain
        assign xp = x_r[i-1][l];
        assign yp = y_r[i-1][l];
        assign zp = z_r[i-1][l];
      end

      // one micro-rotation toward zero residual angle
      always_comb begin
        if (!zp[Z_W-1]) begin
          x_nxt = xp - (yp >>> i);
          y_nxt = yp + (xp >>> i);
          z_nxt = zp - ATAN_I;
        end else begin
          x_nxt = xp + (yp >>> i);
          y_nxt = yp - (xp >>> i);
          z_nxt = zp + ATAN_I;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          x_r[i][l] <= x_nxt;
          y_r[i][l] <= y_nxt;
          z_r[i][l] <= z_nxt;
        end
      end

      if (i == CORDIC_ITERS - 1) begin : g_out
        assign out_x[l] = x_r[i][l];
        assign out_y[l] = y_r[i][l];
      end
    end
  end

  assign out_valid = v_r[CORDIC_ITERS-1];
  assign out_neg   = neg_r[CORDIC_ITERS-1];

endmodule

### rtl/core/gcd_isqrt.sv
// ----------------------------------------------------------------------------
// gcd_isqrt
// Two-lane digit-by-digit floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcd_isqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [gcd_pkg::SQ_N_W-1:0]     in_n   [gcd_pkg::SQ_LANES],
  output logic                           out_valid,
  output logic [gcd_pkg::SQ_OUT_W-1:0]   out_root [gcd_pkg::SQ_LANES]
);
  import gcd_pkg::*;

  localparam int STEPS = SQ_OUT_W;

  logic [SQ_N_W-1:0]   n_r   [STEPS][SQ_LANES];
  logic [SQ_RES_W-1:0] res_r [STEPS][SQ_LANES];
  logic                v_r   [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    localparam logic [SQ_RES_W-1:0] BIT_I = SQ_RES_W'(1) << (2 * (STEPS - 1 - i));
    logic v_in;

    if (i == 0) begin : g_src_in
      assign v_in = in_valid;
    end else begin : g_src_prev
      assign v_in = v_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in;
      end
    end

    for (genvar l = 0; l < SQ_LANES; l++) begin : g_lane
      logic [SQ_N_W-1:0]   np, n_nxt;
      logic [SQ_RES_W-1:0] rp, res_nxt, trial;

      if (i == 0) begin : g_init
        assign np = in_n[l];
        assign rp = '0;
      end else begin : g_chain
        assign np = n_r[i-1][l];
        assign rp = res_r[i-1][l];
      end

      // try the next root bit
      always_comb begin
        trial = rp + BIT_I;
        if ({1'b0, np} >= trial) begin
          n_nxt   = SQ_N_W'({1'b0, np} - trial);
          res_nxt = (rp >> 1) + BIT_I;
        end else begin
          n_nxt   = np;
          res_nxt = rp >> 1;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          n_r[i][l]   <= n_nxt;
          res_r[i][l] <= res_nxt;
        end
      end

      if (i == STEPS - 1) begin : g_out
        assign out_root[l] = res_r[i][l][SQ_OUT_W-1:0];
      end
    end
  end

  assign out_valid = v_r[STEPS-1];

endmodule

### rtl/core/gcd_vec.sv
// ----------------------------------------------------------------------------
// gcd_vec
// Vectoring-mode cordic, one micro-rotation per stage, giving atan2(y, x)
// in q60 radians.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcd_vec (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  gcd_pkg::xy_t  in_x,
  input  gcd_pkg::xy_t  in_y,
  output logic          out_valid,
  output gcd_pkg::ang_t out_z
);
  import gcd_pkg::*;

  xy_t  x_r [CORDIC_ITERS];
  xy_t  y_r [CORDIC_ITERS];
  ang_t z_r [CORDIC_ITERS];
  logic v_r [CORDIC_ITERS];

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_stage
    localparam ang_t ATAN_I = atan_q60(i);
    xy_t  xp, yp, x_nxt, y_nxt;
    ang_t zp, z_nxt;
    logic v_in;

    if (i == 0) begin : g_init
      assign xp   = in_x;
      assign yp   = in_y;
      assign zp   = '0;
      assign v_in = in_valid;
    end else begin : g_chain
      assign xp   = x_r[i-1];
      assign yp   = y_r[i-1];
      assign zp   = z_r[i-1];
      assign v_in = v_r[i-1];
    end

    // drive y toward zero, accumulate the angle
    always_comb begin
      if (!yp[XY_W-1]) begin
        x_nxt = xp + (yp >>> i);
        y_nxt = yp - (xp >>> i);
        z_nxt = zp + ATAN_I;
      end else begin
        x_nxt = xp - (yp >>> i);
        y_nxt = yp + (xp >>> i);
        z_nxt = zp - ATAN_I;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i] <= x_nxt;
        y_r[i] <= y_nxt;
        z_r[i] <= z_nxt;
      end
    end
  end

  assign out_valid = v_r[CORDIC_ITERS-1];
  assign out_z     = z_r[CORDIC_ITERS-1];

endmodule

### rtl/core/gcd_div.sv
// ----------------------------------------------------------------------------
// gcd_div
// Division by the constant pi in q40 through a reciprocal product and one
// remainder correction, turning scaled arc-minutes into miles with fraction
// bits. Five register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcd_div #(
  parameter  int DIST_FRAC_BITS = gcd_pkg::DIST_FRAC_BITS_DEF,
  localparam int QB             = gcd_pkg::QINT_BITS + DIST_FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [gcd_pkg::NUM_W-1:0] in_num,
  output logic                      out_valid,
  output logic [QB-1:0]             out_q
);
  import gcd_pkg::*;

  localparam int LO_W = NUM_W / 2;
  localparam int HI_W = NUM_W - LO_W;
  localparam int RB   = DIST_FRAC_BITS + 17;
  localparam int RW   = 44;
  localparam int DL_W = 32;
  localparam int DH_W = RW - DL_W;
  localparam int NL_W = RW - DIST_FRAC_BITS;

  // floor(2^(NUM_W + DIST_FRAC_BITS) / pi_q40), estimate is low by at most one
  localparam logic [127:0]    RECIP_W =
    (128'd1 << (NUM_W + DIST_FRAC_BITS)) / {64'd0, PI_Q40};
  localparam logic [RB-1:0]   RECIP  = RECIP_W[RB-1:0];
  localparam logic [DL_W-1:0] DIV_LO = PI_Q40[DL_W-1:0];
  localparam logic [DH_W-1:0] DIV_HI = PI_Q40[RW-1:DL_W];
  localparam logic [RW-1:0]   DIV_RW = PI_Q40[RW-1:0];

  // reciprocal partial products
  logic                 v1_r;
  logic [LO_W+RB-1:0]   pl_r;
  logic [HI_W+RB-1:0]   ph_r;
  logic [NL_W-1:0]      n1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r <= {{RB{1'b0}}, in_num[LO_W-1:0]} * {{LO_W{1'b0}}, RECIP};
      ph_r <= {{RB{1'b0}}, in_num[NUM_W-1:LO_W]} * {{HI_W{1'b0}}, RECIP};
      n1_r <= in_num[NL_W-1:0];
    end
  end

  // quotient estimate
  logic                v2_r;
  logic [NUM_W+RB-1:0] full;
  logic [QB-1:0]       est2_r;
  logic [NL_W-1:0]     n2_r;

  assign full = {ph_r, {LO_W{1'b0}}} + {{HI_W{1'b0}}, pl_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      est2_r <= full[NUM_W+QB-1:NUM_W];
      n2_r   <= n1_r;
    end
  end

  // low bits of estimate times divisor
  logic            v3_r;
  logic [RW-1:0]   ml_r;
  logic [DH_W-1:0] mh_r;
  logic [QB-1:0]   est3_r;
  logic [NL_W-1:0] n3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ml_r   <= {{(RW-QB){1'b0}}, est2_r} * {{(RW-DL_W){1'b0}}, DIV_LO};
      mh_r   <= est2_r[DH_W-1:0] * DIV_HI;
      est3_r <= est2_r;
      n3_r   <= n2_r;
    end
  end

  // remainder, below twice the divisor
  logic          v4_r;
  logic [RW-1:0] r4_r;
  logic [QB-1:0] est4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r4_r   <= {n3_r, {DIST_FRAC_BITS{1'b0}}} - ml_r - {mh_r, {DL_W{1'b0}}};
      est4_r <= est3_r;
    end
  end

  // correct the estimate by one
  logic          v5_r;
  logic [QB-1:0] q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= (r4_r >= DIV_RW) ? est4_r + QB'(1) : est4_r;
    end
  end

  assign out_valid = v5_r;
  assign out_q     = q_r;

endmodule

### rtl/core/great_circle_distance.sv
// ----------------------------------------------------------------------------
// great_circle_distance
// Haversine great-circle distance between two points, in nautical miles.
// ----------------------------------------------------------------------------
// Fully pipelined: one coordinate pair is taken every cycle unless the output
// beat is stalled. The depth, whatever DIST_FRAC_BITS, is set by three
// 31-stage chains (sine/cosine cordic, square root, arctangent cordic) and by
// the five-stage division by pi through a reciprocal product. The whole
// pipeline holds on a stalled output beat, so nothing is lost or repeated;
// in_tready follows out_tready through the output register. Distances are
// unsigned with DIST_FRAC_BITS fraction bits and saturate at 10800 miles.
`timescale 1ns / 1ps

module great_circle_distance #(
  parameter  int ANGLE_BITS     = gcd_pkg::ANGLE_BITS_DEF,
  parameter  int DIST_FRAC_BITS = gcd_pkg::DIST_FRAC_BITS_DEF,
  localparam int IN_W           = ((4 * ANGLE_BITS + 7) / 8) * 8,
  localparam int DIST_W         = 14 + DIST_FRAC_BITS,
  localparam int OUT_W          = ((DIST_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // start_latitude, start_longitude, end_latitude, end_longitude
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // distance_nautical
  output logic [OUT_W-1:0] out_tdata
);
  import gcd_pkg::*;

  localparam int A      = ANGLE_BITS;
  localparam int QB     = QINT_BITS + DIST_FRAC_BITS;
  localparam logic [A-1:0] QUARTER = A'(1) << (A - 2);
  localparam logic [A-1:0] HALF    = A'(1) << (A - 1);
  localparam logic [QB-1:0] LIMIT  = QB'(MAX_NM) << DIST_FRAC_BITS;

  logic en;

  // pipeline advances unless the output beat is stalled
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // input capture
  logic         v0_r;
  logic [A-1:0] lat1_r, lon1_r, lat2_r, lon2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lat1_r <= in_tdata[A-1:0];
      lon1_r <= in_tdata[2*A-1:A];
      lat2_r <= in_tdata[3*A-1:2*A];
      lon2_r <= in_tdata[4*A-1:3*A];
    end
  end

  // differences, magnitudes and cosine quadrant fold
  logic         v1_r;
  logic [A-1:0] mag_r [ROT_LANES];
  logic [1:0]   neg_r;
  logic [A-1:0] dlat, dlon, m1, m2;
  logic [A-1:0] mag_nxt [ROT_LANES];
  logic [1:0]   neg_nxt;

  always_comb begin
    dlat       = lat1_r - lat2_r;
    dlon       = lon1_r - lon2_r;
    m1         = lat1_r[A-1] ? A'(-lat1_r) : lat1_r;
    m2         = lat2_r[A-1] ? A'(-lat2_r) : lat2_r;
    mag_nxt[0] = dlat[A-1] ? A'(-dlat) : dlat;
    mag_nxt[1] = dlon[A-1] ? A'(-dlon) : dlon;
    neg_nxt[0] = m1 > QUARTER;
    neg_nxt[1] = m2 > QUARTER;
    mag_nxt[2] = neg_nxt[0] ? A'(HALF - m1) : m1;
    mag_nxt[3] = neg_nxt[1] ? A'(HALF - m2) : m2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= mag_nxt;
      neg_r <= neg_nxt;
    end
  end

  // binary angle times pi, as two partial products
  logic          v2_r;
  logic [A+31:0] pl_r [ROT_LANES];
  logic [A+29:0] ph_r [ROT_LANES];
  logic [1:0]    neg2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < ROT_LANES; l++) begin
        pl_r[l] <= {32'b0, mag_r[l]} * {{A{1'b0}}, PI_LO};
        ph_r[l] <= {30'b0, mag_r[l]} * {{A{1'b0}}, PI_HI};
      end
      neg2_r <= neg_r;
    end
  end

  // combine partial products into q60 radians
  logic          v3_r;
  ang_t          z_r [ROT_LANES];
  logic [1:0]    neg3_r;
  logic [A+61:0] prod [ROT_LANES];
  ang_t          z_nxt [ROT_LANES];

  always_comb begin
    for (int l = 0; l < ROT_LANES; l++) begin
      prod[l] = ({ph_r[l], 32'b0}) + {30'b0, pl_r[l]};
    end
    z_nxt[0] = ang_t'({2'b0, prod[0][A+61:A]});
    z_nxt[1] = ang_t'({2'b0, prod[1][A+61:A]});
    z_nxt[2] = ang_t'({1'b0, prod[2][A+61:A], 1'b0});
    z_nxt[3] = ang_t'({1'b0, prod[3][A+61:A], 1'b0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_r    <= z_nxt;
      neg3_r <= neg2_r;
    end
  end

  // sines of half differences, cosines of latitudes
  logic       rot_v;
  xy_t        rot_x [ROT_LANES];
  xy_t        rot_y [ROT_LANES];
  logic [1:0] rot_neg;

  gcd_rot u_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .in_z      (z_r),
    .in_neg    (neg3_r),
    .out_valid (rot_v),
    .out_x     (rot_x),
    .out_y     (rot_y),
    .out_neg   (rot_neg)
  );

  // squares and cosine product
  logic vm1_r;
  xy_t  p1_r, p2_r, p3_r;
  xy_t  c1, c2;

  assign c1 = rot_neg[0] ? -rot_x[2] : rot_x[2];
  assign c2 = rot_neg[1] ? -rot_x[3] : rot_x[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm1_r <= 1'b0;
    end else if (en) begin
      vm1_r <= rot_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r <= mulq(rot_y[0], rot_y[0]);
      p2_r <= mulq(c1, c2);
      p3_r <= mulq(rot_y[1], rot_y[1]);
    end
  end

  // longitude term
  logic vm2_r;
  xy_t  p1b_r, p4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm2_r <= 1'b0;
    end else if (en) begin
      vm2_r <= vm1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1b_r <= p1_r;
      p4_r  <= mulq(p2_r, p3_r);
    end
  end

  // haversine sum, clamped to [0, 1]
  logic                vm3_r;
  logic [SQ_OUT_W-1:0] h_r;
  logic [XY_W:0]       hs;
  logic [SQ_OUT_W-1:0] h_nxt;

  always_comb begin
    hs = {p1b_r[XY_W-1], p1b_r} + {p4_r[XY_W-1], p4_r};
    if (hs[XY_W]) begin
      h_nxt = '0;
    end else if ($signed(hs) > $signed({TRIG_ONE[XY_W-1], TRIG_ONE})) begin
      h_nxt = SQ_OUT_W'(TRIG_ONE);
    end else begin
      h_nxt = hs[SQ_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm3_r <= 1'b0;
    end else if (en) begin
      vm3_r <= vm2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_r <= h_nxt;
    end
  end

  // sqrt(h) and sqrt(1 - h)
  logic [SQ_N_W-1:0]   sq_in   [SQ_LANES];
  logic [SQ_OUT_W-1:0] sq_root [SQ_LANES];
  logic                sq_v;

  assign sq_in[0] = {h_r, {TRIG_FRAC{1'b0}}};
  assign sq_in[1] = {SQ_OUT_W'(TRIG_ONE) - h_r, {TRIG_FRAC{1'b0}}};

  gcd_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vm3_r),
    .in_n      (sq_in),
    .out_valid (sq_v),
    .out_root  (sq_root)
  );

  // half the central angle
  logic vec_v;
  ang_t vec_z;

  gcd_vec u_vec (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_v),
    .in_x      (xy_t'({{(XY_W-SQ_OUT_W){1'b0}}, sq_root[1]})),
    .in_y      (xy_t'({{(XY_W-SQ_OUT_W){1'b0}}, sq_root[0]})),
    .out_valid (vec_v),
    .out_z     (vec_z)
  );

  // q40 angle times arc-minutes per turn
  logic             vn_r;
  logic [NUM_W-1:0] num_r;
  ang_t             zc;

  assign zc = vec_z[Z_W-1] ? '0 : vec_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vn_r <= 1'b0;
    end else if (en) begin
      vn_r <= vec_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= NUM_W'(zc[Z_W-2:20]) * NUM_W'(MIN_PER_TURN);
    end
  end

  // divide by pi
  logic          div_v;
  logic [QB-1:0] div_q;

  gcd_div #(
    .DIST_FRAC_BITS (DIST_FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vn_r),
    .in_num    (num_r),
    .out_valid (div_v),
    .out_q     (div_q)
  );

  // saturate and register the output beat
  logic              vout_r;
  logic [DIST_W-1:0] dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vout_r <= 1'b0;
    end else if (en) begin
      vout_r <= div_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= (div_q > LIMIT) ? LIMIT[DIST_W-1:0] : div_q[DIST_W-1:0];
    end
  end

  assign out_tvalid = vout_r;
  assign out_tdata  = OUT_W'(dist_r);

endmodule
